FILE: design/ihs_pkg.sv
// Package for the inode seen-set block: controller states, command and status
// structs, and fixed field widths. No dependencies.
`default_nettype none

package ihs_pkg;

  // Field widths of the stream payloads.
  localparam int DEV_W  = 32;
  localparam int INO_W  = 32;
  localparam int KEY_W  = DEV_W + INO_W;
  localparam int IN_W   = 64;
  localparam int OUT_W  = 8;

  // Bit positions of the result fields inside out_tdata.
  localparam int OUT_SEEN_BIT = 0;
  localparam int OUT_OVF_BIT  = 1;

  // The bucket remainder is formed by a reciprocal multiply in MOD_STEPS
  // steps: product, multiply back, subtract.
  localparam int MOD_STEPS = 3;
  localparam int STEP_W    = $clog2(MOD_STEPS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_HEAD_RD,
    ST_ENT_RD,
    ST_ENT_CMP,
    ST_DONE
  } ihs_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;     // write one empty bucket head and advance the sweep
    logic load_key;   // capture the incoming pair, restart the remainder
    logic mod_step;   // one remainder step
    logic head_rd;    // read the bucket head into the link register
    logic ent_rd;     // read the entry that the link points at
    logic link_next;  // follow the chain to the older entry
    logic set_hit;    // the pair was found in the chain
    logic finish;     // load the result register, insert when new and not full
  } ihs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;   // the sweep is at the last bucket
    logic link_zero;  // the current link is empty
    logic match;      // the entry just read holds the pair
    logic full;       // every entry is in use
    logic out_busy;   // a result waits and is not taken this cycle
  } ihs_sts_t;

endpackage

`default_nettype wire

FILE: design/ihs_ctrl.sv
// Controller state machine of the inode seen-set block.
// Depends on ihs_pkg for the state enum and the command and status structs.
`default_nettype none

module ihs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire ihs_pkg::ihs_sts_t sts,
  output ihs_pkg::ihs_cmd_t     cmd
);

  ihs_pkg::ihs_state_t state_r, state_nxt;
  logic [ihs_pkg::STEP_W-1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ihs_pkg::ST_CLEAR;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ihs_pkg::ST_CLEAR: begin
        if (sts.clr_done) state_nxt = ihs_pkg::ST_IDLE;
      end
      ihs_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ihs_pkg::ST_MOD;
          step_nxt  = '0;
        end
      end
      ihs_pkg::ST_MOD: begin
        step_nxt = step_r + 1'b1;
        if (step_r == ihs_pkg::STEP_W'(ihs_pkg::MOD_STEPS - 1)) state_nxt = ihs_pkg::ST_HEAD_RD;
      end
      ihs_pkg::ST_HEAD_RD: begin
        state_nxt = ihs_pkg::ST_ENT_RD;
      end
      ihs_pkg::ST_ENT_RD: begin
        if (sts.link_zero) state_nxt = ihs_pkg::ST_DONE;
        else state_nxt = ihs_pkg::ST_ENT_CMP;
      end
      ihs_pkg::ST_ENT_CMP: begin
        if (sts.match) state_nxt = ihs_pkg::ST_DONE;
        else state_nxt = ihs_pkg::ST_ENT_RD;
      end
      ihs_pkg::ST_DONE: begin
        if (!sts.out_busy) state_nxt = ihs_pkg::ST_IDLE;
      end
      default: state_nxt = ihs_pkg::ST_CLEAR;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ihs_pkg::ST_CLEAR:   cmd.clr_wr = 1'b1;
      ihs_pkg::ST_IDLE: begin
        in_tready    = 1'b1;
        cmd.load_key = in_tvalid;
      end
      ihs_pkg::ST_MOD:     cmd.mod_step = 1'b1;
      ihs_pkg::ST_HEAD_RD: cmd.head_rd = 1'b1;
      ihs_pkg::ST_ENT_RD:  cmd.ent_rd = !sts.link_zero;
      ihs_pkg::ST_ENT_CMP: begin
        cmd.set_hit   = sts.match;
        cmd.link_next = !sts.match;
      end
      ihs_pkg::ST_DONE:    cmd.finish = !sts.out_busy;
      default:             cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/ihs_datapath.sv
// Datapath of the inode seen-set block: remainder unit, bucket head memory,
// entry memories, fill count and the result register. Depends on ihs_pkg.
`default_nettype none

module ihs_datapath #(
  parameter int BUCKETS = 256,
  parameter int ENTRIES = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [ihs_pkg::DEV_W-1:0] dev_in,
  input  wire logic [ihs_pkg::INO_W-1:0] ino_in,
  input  wire ihs_pkg::ihs_cmd_t        cmd,
  output ihs_pkg::ihs_sts_t             sts,
  input  wire logic                     out_tready,
  output logic                          out_valid,
  output logic                          out_seen,
  output logic                          out_ovf
);

  localparam int BW = $clog2(BUCKETS);
  localparam int EW = $clog2(ENTRIES);
  localparam int LW = $clog2(ENTRIES + 1);
  // Reciprocal for the bucket remainder: ceil(2^RS / BUCKETS) gives an exact
  // quotient for every 32-bit inode when RS is 32 plus ceil(log2(BUCKETS)).
  localparam int RS  = ihs_pkg::INO_W + BW;
  localparam int PW  = 2 * ihs_pkg::INO_W + 1;
  localparam int QW  = PW - RS;
  localparam int QBW = QW + BW + 1;
  localparam logic [ihs_pkg::INO_W:0] RECIP_M = (ihs_pkg::INO_W + 1)'(
    ((64'd1 << RS) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

  // Links hold entry index plus one; zero is the empty link.
  logic [LW-1:0]                head_mem [BUCKETS];
  logic [ihs_pkg::KEY_W-1:0]    key_mem  [ENTRIES];
  logic [LW-1:0]                next_mem [ENTRIES];

  logic [ihs_pkg::KEY_W-1:0] key_r;
  logic [PW-1:0]             prod_r;
  logic [ihs_pkg::INO_W-1:0] qb_r;
  logic [BW-1:0]             rem_r;
  logic [LW-1:0]             link_r;
  logic [LW-1:0]             head_q_r;
  logic [ihs_pkg::KEY_W-1:0] ekey_q_r;
  logic [LW-1:0]             enext_q_r;
  logic [LW-1:0]             fill_r;
  logic [BW-1:0]             clr_r;
  logic                      hit_r;
  logic                      out_valid_r;
  logic                      seen_r;
  logic                      ovf_r;
  logic                      full;
  logic                      ins;
  logic [EW-1:0]             ent_idx;
  logic [EW-1:0]             wr_idx;

  assign full    = (fill_r == LW'(ENTRIES));
  assign ins     = cmd.finish && !hit_r && !full;
  assign ent_idx = EW'(link_r - LW'(1));
  assign wr_idx  = EW'(fill_r);

  // The remainder pipeline advances on every step; each stage holds its final
  // value one step after the stage before it, so rem_r is ready after
  // MOD_STEPS steps.
  always_ff @(posedge clk) begin
    if (cmd.load_key) key_r <= {dev_in, ino_in};
    if (cmd.mod_step) begin
      prod_r <= PW'(key_r[ihs_pkg::INO_W-1:0]) * PW'(RECIP_M);
      qb_r   <= ihs_pkg::INO_W'(QBW'(prod_r[PW-1:RS]) * QBW'(BUCKETS));
      rem_r  <= BW'(key_r[ihs_pkg::INO_W-1:0] - qb_r);
    end
  end

  // Bucket head memory: one write port (clearing sweep or insert), one read.
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) head_mem[clr_r] <= '0;
    else if (ins) head_mem[rem_r] <= fill_r + LW'(1);
    if (cmd.head_rd) head_q_r <= head_mem[rem_r];
  end

  // Entry memories: written at the fill position, read at the current link.
  always_ff @(posedge clk) begin
    if (ins) begin
      key_mem[wr_idx]  <= key_r;
      next_mem[wr_idx] <= head_q_r;
    end
    if (cmd.ent_rd) begin
      ekey_q_r  <= key_mem[ent_idx];
      enext_q_r <= next_mem[ent_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.head_rd) link_r <= head_mem[rem_r];
    else if (cmd.link_next) link_r <= enext_q_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      seen_r <= hit_r;
      ovf_r  <= !hit_r && full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      clr_r       <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_r <= clr_r + BW'(1);
      if (ins) fill_r <= fill_r + LW'(1);
      if (cmd.load_key) hit_r <= 1'b0;
      else if (cmd.set_hit) hit_r <= 1'b1;
      if (cmd.finish) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign sts.clr_done  = (clr_r == BW'(BUCKETS - 1));
  assign sts.link_zero = (link_r == '0);
  assign sts.match     = (ekey_q_r == key_r);
  assign sts.full      = full;
  assign sts.out_busy  = out_valid_r && !out_tready;

  assign out_valid = out_valid_r;
  assign out_seen  = seen_r;
  assign out_ovf   = ovf_r;

endmodule

`default_nettype wire

FILE: design/inode_seen_hash_set_top.sv
// Top level of the inode seen-set block: controller plus datapath.
// Depends on ihs_pkg, ihs_ctrl and ihs_datapath.
//
// Usage: each transfer on the in_ channel carries one (device, inode) pair.
// The block hashes the inode modulo BUCKETS, walks that bucket's chain of
// stored pairs newest first, and returns one transfer on the out_ channel:
// seen=1 if the pair was already stored; otherwise it is appended as the new
// chain head and seen=0, or, when all ENTRIES entries are in use, it is
// dropped with seen=0 and overflow=1.
// The bucket remainder is formed by a reciprocal multiply, a multiply back
// and a subtract; each chain entry costs a read and a compare. One item is
// worked at a time; the input is ready again in the cycle after the result
// is loaded.
// Reset: the bucket head memory is swept empty, one bucket per cycle, so
// in_tready stays low until the sweep is done. The fill count and the
// result valid flag clear at once.
// Stalls: the result sits in an output register; the next input is taken
// while it waits, and a new result waits only if the old one is still held.
`default_nettype none

module inode_seen_hash_set_top #(
  parameter int BUCKETS = 256,
  parameter int ENTRIES = 1024
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // in_tdata: [31:0] device_id, [63:32] inode_number
  input  wire logic [ihs_pkg::IN_W-1:0] in_tdata,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  // out_tdata: [0] seen, [1] overflow, [7:2] zero
  output logic [ihs_pkg::OUT_W-1:0]    out_tdata,
  output logic                         out_tvalid,
  input  wire logic                    out_tready
);

  ihs_pkg::ihs_cmd_t cmd;
  ihs_pkg::ihs_sts_t sts;
  logic              seen;
  logic              ovf;

  ihs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ihs_datapath #(
    .BUCKETS (BUCKETS),
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .dev_in     (in_tdata[ihs_pkg::DEV_W-1:0]),
    .ino_in     (in_tdata[ihs_pkg::KEY_W-1:ihs_pkg::DEV_W]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_seen   (seen),
    .out_ovf    (ovf)
  );

  assign out_tdata = {(ihs_pkg::OUT_W - 2)'(0), ovf, seen};

  // An entry is only ever read through a non-empty link.
  a_no_null_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ent_rd |-> !sts.link_zero)
    else $error("entry read through an empty link");

  // One item at a time: after an accepted transfer the input is closed.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input reopened while an item is in work");

  // Overflow is reported only while the store is full.
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[ihs_pkg::OUT_OVF_BIT]) |-> sts.full)
    else $error("overflow reported with free entries");

  // A new result appears only from the finishing step of the controller.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.finish))
    else $error("result valid without a finished item");

endmodule

`default_nettype wire
